FILE: design/sca_pkg.sv
// Package for the sine correlation analyser: fixed widths, register map,
// state type and the CORDIC arctangent table. No dependencies.
package sca_pkg;

    localparam int SMP_W    = 16;
    localparam int STEP_W   = 31;
    localparam int PH_W     = 32;
    localparam int CYC_W    = 14;
    localparam int AMP_W    = 17;
    localparam int DEG_W    = 16;
    localparam int FRAC     = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int CORDIC_STEPS = 28;
    localparam int CNT_W    = 5;
    localparam int CX_W     = 38;
    localparam int CZ_W     = 34;
    localparam int CS_W     = 18;
    localparam int AVG_W    = 36;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 46;
    localparam int DIV_CNT_W = 6;
    localparam int SQ_W     = 63;
    localparam int SH_W     = 3;

    localparam logic [0:0] REG_AVG_CYCLES = 1'b0;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 38'sd652032874;
    localparam logic [AMP_W-1:0]       AMP_MAX     = 17'd131071;
    localparam logic signed [AVG_W-1:0] DEG_HALF   = 36'sd23040;
    localparam logic signed [MUL_W-1:0] DEG_SCALE  = 34'sd46080;

    typedef enum logic [4:0] {
        S_IDLE, S_ROT, S_ROT_FIN, S_TC_WAIT, S_MUL_C, S_MUL_S, S_DIV_RE, S_WAIT_RE,
        S_DIV_IM, S_WAIT_IM, S_ABS, S_NORM, S_SQ_A, S_SQ_B, S_SQ_SUM, S_SQRT,
        S_VEC_INIT, S_VEC, S_DEG_MUL, S_DEG_FIN, S_OUT
    } t_state;

    function automatic logic [29:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/sca_if.sv
// Item channels of the sine correlation analyser: sample input and result output.
// Depends on nothing; widths follow the package constants.
interface sca_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [30:0]        phase_step;
    modport source(output valid, sample, phase_step, input ready);
    modport sink(input valid, sample, phase_step, output ready);
endinterface

interface sca_out_if;
    logic               valid;
    logic               ready;
    logic [16:0]        amplitude;
    logic signed [15:0] phase_deg;
    modport source(output valid, amplitude, phase_deg, input ready);
    modport sink(input valid, amplitude, phase_deg, output ready);
endinterface

FILE: design/sine_correlation_analyzer_unit.sv
// Sine correlation analyser top level: CORDIC, shared divider, square root, APB register.
// Depends on sca_pkg and the channel interfaces in sca_if.sv.
// A new item is taken only in the idle state, once the previous result has gone into the
// output register. A zero step goes straight to the output, and the vectoring CORDIC is
// skipped when both filters are zero. The time constant division and the two filter
// divisions share the bit-serial divider; the CORDIC runs twice, rotating then vectoring.
// Synchronous active-low reset clears the phase and the filters and sets the register to 1.
module sine_correlation_analyzer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sca_in_if.sink                           i_item,
    sca_out_if.source                        o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sca_pkg::PADDR_W-1:0]      paddr,
    input  logic [sca_pkg::PDATA_W-1:0]      pwdata,
    output logic [sca_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import sca_pkg::*;

    t_state r_state, n_state;

    logic [CYC_W-1:0]        r_cyc;
    logic [PH_W-1:0]         r_phase_acc;
    logic [STEP_W-1:0]       r_last_step;
    logic signed [AVG_W-1:0] r_re, r_im;
    logic signed [SMP_W-1:0] r_smp;

    logic signed [CX_W-1:0]  r_cx, r_cy;
    logic signed [CZ_W-1:0]  r_cz;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_rot, r_flip;
    logic signed [CS_W-1:0]  r_c, r_s;

    logic [DIV_W-1:0]        r_tc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [AVG_W-1:0] r_pre, r_pim;

    logic                    r_div_busy;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    logic [DIV_W-1:0]        r_div_rem, r_div_dvd, r_div_dvs, r_div_quo;
    logic                    r_neg;

    logic [AVG_W-1:0]        r_ma, r_mb;
    logic [SH_W-1:0]         r_sh;
    logic [SQ_W-2:0]         r_sq;
    logic [SQ_W-1:0]         r_sqn, r_res, r_bit;

    logic [AMP_W-1:0]        r_amp, r_out_amp;
    logic signed [DEG_W-1:0] r_deg, r_out_deg;
    logic                    r_out_valid;

    logic                    in_fire, out_take, out_load, cfg_wr;
    logic [STEP_W-1:0]       step_in;
    logic [PH_W-1:0]         n_phase, ph_quarter, rot_ang;
    logic [CYC_W-1:0]        cyc_eff;

    logic signed [CX_W-1:0]  cdx, cdy, fx, fy, rx, ry;
    logic signed [CZ_W-1:0]  catan;
    logic                    c_pos;

    logic signed [MUL_W-1:0] mul_a, mul_b;

    logic                    div_start;
    logic [DIV_W-1:0]        div_dvd_in, div_dvs_in;
    logic                    div_neg_in;
    logic [DIV_W:0]          div_trial;
    logic                    div_ge;
    logic signed [AVG_W-1:0] diff_re, diff_im, q_signed;
    logic [AVG_W-1:0]        abs_re, abs_im;

    logic [SQ_W:0]           sq_sum;
    logic                    sq_ge;
    logic [39:0]             m_sh;
    logic [24:0]             amp_rnd;
    logic signed [PROD_W-1:0] deg_sum;
    logic signed [AVG_W-1:0] deg_q;

    assign step_in    = i_item.phase_step;
    assign in_fire    = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign out_take   = r_out_valid && o_res.ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_res.ready);
    assign o_res.valid     = r_out_valid;
    assign o_res.amplitude = r_out_amp;
    assign o_res.phase_deg = r_out_deg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_AVG_CYCLES);
    assign prdata = (paddr[2] == REG_AVG_CYCLES) ? {{(PDATA_W-CYC_W){1'b0}}, r_cyc}
                                                 : '0;

    assign cyc_eff    = (r_cyc == '0) ? CYC_W'(1) : r_cyc;
    assign n_phase    = r_phase_acc + {1'b0, step_in};
    assign ph_quarter = n_phase + 32'h4000_0000;
    assign rot_ang    = ph_quarter[PH_W-1] ? (n_phase ^ 32'h8000_0000) : n_phase;

    assign cdx   = r_cy >>> r_cnt;
    assign cdy   = r_cx >>> r_cnt;
    assign catan = $signed({4'b0, atan_turn(r_cnt)});
    assign c_pos = r_rot ? !r_cz[CZ_W-1] : r_cy[CX_W-1];

    assign fx = r_flip ? -r_cx : r_cx;
    assign fy = r_flip ? -r_cy : r_cy;
    assign rx = (fx + 38'sd8192) >>> 14;
    assign ry = (fy + 38'sd8192) >>> 14;

    assign diff_re  = r_pre - r_re;
    assign diff_im  = r_pim - r_im;
    assign abs_re   = r_re[AVG_W-1] ? AVG_W'(-r_re) : AVG_W'(r_re);
    assign abs_im   = r_im[AVG_W-1] ? AVG_W'(-r_im) : AVG_W'(r_im);
    assign q_signed = r_neg ? -$signed(r_div_quo[AVG_W-1:0])
                            : $signed(r_div_quo[AVG_W-1:0]);

    assign div_trial = {r_div_rem, r_div_dvd[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_div_dvs};

    assign sq_sum  = {1'b0, r_res} + {1'b0, r_bit};
    assign sq_ge   = {1'b0, r_sqn} >= sq_sum;
    assign m_sh    = {7'b0, r_res[32:0]} << r_sh;
    assign amp_rnd = 25'((m_sh + 40'd16384) >> 15);
    assign deg_sum = r_prod + 68'sh8000_0000;
    assign deg_q   = deg_sum[PROD_W-1:32];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_C: begin
                mul_a = MUL_W'(r_smp);
                mul_b = MUL_W'(r_c);
            end
            S_MUL_S: begin
                mul_a = MUL_W'(r_smp);
                mul_b = MUL_W'(r_s);
            end
            S_SQ_A: begin
                mul_a = $signed({3'b0, r_ma[30:0]});
                mul_b = $signed({3'b0, r_ma[30:0]});
            end
            S_SQ_B: begin
                mul_a = $signed({3'b0, r_mb[30:0]});
                mul_b = $signed({3'b0, r_mb[30:0]});
            end
            S_DEG_MUL: begin
                mul_a = r_cz;
                mul_b = DEG_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        div_dvd_in = '0;
        div_dvs_in = '0;
        div_neg_in = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (step_in == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state    = S_ROT;
                        div_start  = 1'b1;
                        div_dvd_in = {cyc_eff, 32'b0};
                        div_dvs_in = {{(DIV_W-STEP_W){1'b0}}, step_in};
                    end
                end
            end
            S_ROT: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = S_ROT_FIN;
            end
            S_ROT_FIN: n_state = S_TC_WAIT;
            S_TC_WAIT: begin
                if (!r_div_busy) n_state = S_MUL_C;
            end
            S_MUL_C: n_state = S_MUL_S;
            S_MUL_S: n_state = S_DIV_RE;
            S_DIV_RE: begin
                n_state    = S_WAIT_RE;
                div_start  = 1'b1;
                div_neg_in = diff_re[AVG_W-1];
                div_dvd_in = DIV_W'(diff_re[AVG_W-1] ? AVG_W'(-diff_re) : AVG_W'(diff_re));
                div_dvs_in = r_tc;
            end
            S_WAIT_RE: begin
                if (!r_div_busy) n_state = S_DIV_IM;
            end
            S_DIV_IM: begin
                n_state    = S_WAIT_IM;
                div_start  = 1'b1;
                div_neg_in = diff_im[AVG_W-1];
                div_dvd_in = DIV_W'(diff_im[AVG_W-1] ? AVG_W'(-diff_im) : AVG_W'(diff_im));
                div_dvs_in = r_tc;
            end
            S_WAIT_IM: begin
                if (!r_div_busy) n_state = S_ABS;
            end
            S_ABS: n_state = S_NORM;
            S_NORM: begin
                if (r_ma[AVG_W-1:31] == '0 && r_mb[AVG_W-1:31] == '0) n_state = S_SQ_A;
            end
            S_SQ_A:   n_state = S_SQ_B;
            S_SQ_B:   n_state = S_SQ_SUM;
            S_SQ_SUM: n_state = S_SQRT;
            S_SQRT: begin
                if (r_bit == '0) n_state = S_VEC_INIT;
            end
            S_VEC_INIT: begin
                if (r_re == '0 && r_im == '0) n_state = S_DEG_MUL;
                else n_state = S_VEC;
            end
            S_VEC: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = S_DEG_MUL;
            end
            S_DEG_MUL: n_state = S_DEG_FIN;
            S_DEG_FIN: n_state = S_OUT;
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyc       <= CYC_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_cyc <= pwdata[CYC_W-1:0];
            r_out_valid <= out_load || (r_out_valid && !out_take);
        end
        if (out_load) begin
            r_out_amp <= r_amp;
            r_out_deg <= r_deg;
        end
    end

    // Bit-serial restoring divider, shared by the time constant and both filters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (div_start) begin
            r_div_busy <= 1'b1;
        end else if (r_div_busy && r_div_cnt == '0) begin
            r_div_busy <= 1'b0;
        end
        if (div_start) begin
            r_div_cnt <= DIV_CNT_W'(DIV_W - 1);
            r_div_rem <= '0;
            r_div_dvd <= div_dvd_in;
            r_div_dvs <= div_dvs_in;
            r_div_quo <= '0;
            r_neg     <= div_neg_in;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            r_div_rem <= div_ge ? DIV_W'(div_trial - {1'b0, r_div_dvs}) : div_trial[DIV_W-1:0];
            r_div_dvd <= {r_div_dvd[DIV_W-2:0], 1'b0};
            r_div_quo <= {r_div_quo[DIV_W-2:0], div_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_last_step <= '0;
            r_re        <= '0;
            r_im        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire && step_in != '0) begin
                        r_phase_acc <= n_phase;
                        if (step_in != r_last_step) begin
                            r_last_step <= step_in;
                            r_re        <= '0;
                            r_im        <= '0;
                        end
                    end
                end
                S_WAIT_RE: begin
                    if (!r_div_busy) r_re <= r_re + q_signed;
                end
                S_WAIT_IM: begin
                    if (!r_div_busy) r_im <= r_im + q_signed;
                end
                default: begin
                end
            endcase
        end
        case (r_state)
            S_IDLE: begin
                r_smp  <= i_item.sample;
                r_amp  <= '0;
                r_deg  <= '0;
                r_rot  <= 1'b1;
                r_flip <= ph_quarter[PH_W-1];
                r_cx   <= CORDIC_GAIN;
                r_cy   <= '0;
                r_cz   <= {{(CZ_W-PH_W){rot_ang[PH_W-1]}}, rot_ang};
                r_cnt  <= '0;
            end
            S_ROT, S_VEC: begin
                if (c_pos) begin
                    r_cx <= r_cx - cdx;
                    r_cy <= r_cy + cdy;
                    r_cz <= r_cz - catan;
                end else begin
                    r_cx <= r_cx + cdx;
                    r_cy <= r_cy - cdy;
                    r_cz <= r_cz + catan;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_ROT_FIN: begin
                r_c <= rx[CS_W-1:0];
                r_s <= ry[CS_W-1:0];
            end
            S_TC_WAIT: begin
                if (!r_div_busy) r_tc <= (r_div_quo == '0) ? DIV_W'(1) : r_div_quo;
            end
            S_MUL_S:  r_pre <= r_prod[AVG_W-1:0];
            S_DIV_RE: r_pim <= r_prod[AVG_W-1:0];
            S_ABS: begin
                r_ma <= abs_re;
                r_mb <= abs_im;
                r_sh <= '0;
            end
            S_NORM: begin
                if (r_ma[AVG_W-1:31] != '0 || r_mb[AVG_W-1:31] != '0) begin
                    r_ma <= r_ma >> 1;
                    r_mb <= r_mb >> 1;
                    r_sh <= r_sh + 1'b1;
                end
            end
            S_SQ_B:   r_sq <= r_prod[SQ_W-2:0];
            S_SQ_SUM: begin
                r_sqn <= {1'b0, r_sq} + {1'b0, r_prod[SQ_W-2:0]};
                r_res <= '0;
                r_bit <= {1'b1, {(SQ_W-1){1'b0}}};
            end
            S_SQRT: begin
                if (r_bit != '0) begin
                    if (sq_ge) begin
                        r_sqn <= r_sqn - sq_sum[SQ_W-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            S_VEC_INIT: begin
                r_amp <= (amp_rnd > {8'b0, AMP_MAX}) ? AMP_MAX : amp_rnd[AMP_W-1:0];
                r_rot <= 1'b0;
                r_cnt <= '0;
                if (r_re[AVG_W-1]) begin
                    r_cx <= -CX_W'(r_re);
                    r_cy <= -CX_W'(r_im);
                    r_cz <= r_im[AVG_W-1] ? -34'sh0_8000_0000 : 34'sh0_8000_0000;
                end else begin
                    r_cx <= CX_W'(r_re);
                    r_cy <= CX_W'(r_im);
                    r_cz <= '0;
                end
            end
            S_DEG_FIN: begin
                if (deg_q > DEG_HALF) r_deg <= DEG_W'(DEG_HALF);
                else if (deg_q < -DEG_HALF) r_deg <= DEG_W'(-DEG_HALF);
                else r_deg <= deg_q[DEG_W-1:0];
            end
            default: begin
            end
        endcase
    end

    a_zero_step_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && step_in == '0) |=> $stable(r_phase_acc))
        else $error("zero step changed the phase accumulator");

    a_last_step_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && step_in != '0) |=> (r_last_step == $past(step_in)))
        else $error("last step not taken from the accepted item");

    a_divider_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_div_busy)
        else $error("divider still busy when the result is presented");

endmodule

FILE: tb/sv/sca_checker.sv
// Checker for the sine correlation analyser: watches the item channels and the APB port,
// predicts every result in fixed point and compares it with the block's output.
// Depends on sca_pkg and the channel interfaces in sca_if.sv.
module sca_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sca_in_if                           in_ch,
    sca_out_if                          res_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sca_pkg::PADDR_W-1:0] paddr,
    input  logic [sca_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sca_pkg::*;

    typedef struct packed {
        logic [AMP_W-1:0]        amp;
        logic signed [DEG_W-1:0] deg;
    } t_result;

    localparam longint ARC_TURN [CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005
    };

    logic [CYC_W-1:0] avg_cycles;
    logic [PH_W-1:0]  phase;
    logic [PH_W-1:0]  prev_step;
    longint           re_lag;
    longint           im_lag;
    t_result          expected_q [$];

    assign o_pending = expected_q.size();

    function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] a;
        logic [31:0] probe;
        logic        flip;
        longint      x, y, z, dx, dy;
        a = ang;
        probe = a + 32'h40000000;
        flip = probe[31];
        if (flip) begin
            a = a - 32'h80000000;
        end
        x = CORDIC_GAIN;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARC_TURN[i];
            end else begin
                x += dx; y -= dy; z += ARC_TURN[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = (x + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        s = (y + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    function automatic longint vector_angle(input longint xi, input longint yi);
        longint x, y, z, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARC_TURN[i];
            end else begin
                x -= dx; y += dy; z -= ARC_TURN[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned root_of(input longint unsigned n_in);
        longint unsigned n, res, b;
        n = n_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) begin
            b >>= 2;
        end
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_result correlate(input logic signed [SMP_W-1:0] smp,
                                          input logic [STEP_W-1:0] stp);
        t_result         r;
        logic [PH_W-1:0] step_v;
        longint unsigned cyc, tc, a, b, m, amp;
        longint          c, s, z, deg;
        int              sh;
        r = '0;
        step_v = PH_W'(stp);
        if (step_v == 0) begin
            return r;
        end
        cyc = (avg_cycles != 0) ? longint'(avg_cycles) : 1;
        if (step_v != prev_step) begin
            prev_step = step_v;
            re_lag = 0;
            im_lag = 0;
        end
        phase = phase + step_v;
        rotate(phase, c, s);
        tc = (cyc << 32) / longint'(step_v);
        if (tc == 0) begin
            tc = 1;
        end
        re_lag += (longint'(smp) * c - re_lag) / longint'(tc);
        im_lag += (longint'(smp) * s - im_lag) / longint'(tc);
        a = (re_lag < 0) ? -re_lag : re_lag;
        b = (im_lag < 0) ? -im_lag : im_lag;
        sh = 0;
        while (a >= (64'd1 << 31) || b >= (64'd1 << 31)) begin
            a >>= 1;
            b >>= 1;
            sh++;
        end
        m = root_of(a * a + b * b) << sh;
        amp = (m + (64'd1 << (FRAC - 2))) >> (FRAC - 1);
        if (amp > AMP_MAX) begin
            amp = AMP_MAX;
        end
        z = vector_angle(re_lag, im_lag);
        deg = (z * 46080 + (64'sd1 <<< 31)) >>> 32;
        if (deg > DEG_HALF) begin
            deg = DEG_HALF;
        end
        if (deg < -DEG_HALF) begin
            deg = -DEG_HALF;
        end
        r.amp = AMP_W'(amp);
        r.deg = DEG_W'(deg);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            avg_cycles <= CYC_W'(1);
            phase = '0;
            prev_step = '0;
            re_lag = 0;
            im_lag = 0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_AVG_CYCLES) begin
                avg_cycles <= pwdata[CYC_W-1:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_q.push_back(correlate(in_ch.sample, in_ch.phase_step));
            end
            if (res_ch.valid && res_ch.ready) begin
                got.amp = res_ch.amplitude;
                got.deg = res_ch.phase_deg;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: amplitude %0d phase_deg %0d", got.amp, got.deg);
                    bad++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.amp !== want.amp) begin
                        $error("amplitude: expected %0d, actual %0d", want.amp, got.amp);
                        bad++;
                    end
                    if (got.deg !== want.deg) begin
                        $error("phase_deg: expected %0d, actual %0d", want.deg, got.deg);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the sine correlation analyser testbench: clock, reset, APB writes and item stimulus.
// Depends on sca_pkg, sca_if.sv, the block itself and the checker in sca_checker.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sca_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_CYCLES = {REG_AVG_CYCLES, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 burst_left = 0;
    int                 stall_mode = 0;

    sca_in_if  item_ch ();
    sca_out_if res_ch ();

    sine_correlation_analyzer_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sca_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(item_ch), .res_ch(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_errors(errors), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // The receiver changes its stall pattern at random times; one mode never stalls.
    always @(posedge i_clk) begin
        if ($urandom_range(199) == 0) begin
            stall_mode <= $urandom_range(2);
        end
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= $urandom_range(1);
            default: res_ch.ready <= ($urandom_range(3) == 0);
        endcase
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send(input logic signed [SMP_W-1:0] smp, input logic [STEP_W-1:0] stp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.sample <= smp;
        item_ch.phase_step <= stp;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic stop_items();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(5))
            0: return STEP_W'($urandom);
            1: return STEP_W'($urandom_range(1, 255));
            2: return {1'b1, 30'($urandom)};
            3: return STEP_W'($urandom_range(1 << 20, 1 << 27));
            4: return 31'h7FFFFFFF;
            default: return STEP_W'($urandom_range(1 << 24, 1 << 30));
        endcase
    endfunction

    // A run of one frequency with a noisy sine of random amplitude, mixed with noise.
    task automatic random_run(input int n);
        logic [STEP_W-1:0] stp;
        int                amp, n_left;
        real               ph, dph;
        stp = pick_step();
        amp = $urandom_range(32767);
        ph = 0.0;
        dph = 6.283185307 * real'(stp) / 4294967296.0;
        n_left = n;
        while (n_left > 0) begin
            if ($urandom_range(15) == 0) begin
                send(SMP_W'($urandom), ($urandom_range(3) == 0) ? '0 : pick_step());
            end else begin
                ph = ph + dph;
                send(SMP_W'(SMP_W'($rtoi(real'(amp) * $sin(ph + 0.7)))
                     + $signed(SMP_W'($urandom_range(64))) - 32), stp);
            end
            n_left--;
        end
    endtask

    initial begin
        logic [CYC_W-1:0] cyc_set [5];
        item_ch.valid = 1'b0;
        item_ch.sample = '0;
        item_ch.phase_step = '0;
        cyc_set = '{14'd1, 14'd10000, 14'd0, 14'h3FFF, 14'd50};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(16'sh7FFF, 31'd0);
        send(-16'sd32768, 31'h7FFFFFFF);
        send(16'sh7FFF, 31'h7FFFFFFF);
        send(16'sd0, 31'h7FFFFFFF);
        send(-16'sd32768, 31'h40000000);
        send(16'sh7FFF, 31'h40000000);
        send(16'sh1234, 31'd1);
        send(-16'sd1, 31'd1);
        send(16'sh7FFF, 31'h20000000);
        send(16'sh7FFF, 31'd0);
        send(-16'sd32768, 31'h20000000);
        send(16'sh5555, 31'h2AAAAAAA);
        send(-16'sh5556, 31'h55555555);
        for (int k = 0; k < 8; k++) begin
            send((k % 2) ? -16'sd32768 : 16'sh7FFF, 31'h40000000);
        end
        stop_items();
        drain();
        apb_write(ADDR_UNUSED, 32'd7);
        send(16'sh7FFF, 31'h10000000);
        stop_items();
        drain();

        for (int p = 0; p < 6; p++) begin
            apb_write(ADDR_CYCLES, (p < 5) ? PDATA_W'(cyc_set[p])
                                           : PDATA_W'($urandom_range(1, 10000)));
            for (int r = 0; r < 4; r++) begin
                random_run($urandom_range(5, 45));
            end
            stop_items();
            drain();
        end
        // Random register values between further runs, with random upper bits in the write.
        for (int p = 0; p < 4; p++) begin
            apb_write(ADDR_CYCLES, {18'($urandom), 14'($urandom_range(1, 10000))});
            for (int r = 0; r < 5; r++) begin
                random_run($urandom_range(5, 40));
            end
            stop_items();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("sine_correlation_analyzer_unit: match");
        end else begin
            $display("sine_correlation_analyzer_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("sine_correlation_analyzer_unit: mismatch");
        $finish;
    end

endmodule
